[rtl/rdfa_pkg.sv]
package rdfa_pkg;

  // Data widths fixed by the item format
  localparam int ACC_W     = 64;   // accumulators and averages
  localparam int CNT_W     = 16;   // snapshot counter
  localparam int POINT_W   = 10;
  localparam int VALUE_W   = 24;
  localparam int TIME_W    = 32;
  localparam int WORD_W    = 32;
  localparam int BIN_W     = 2;
  localparam int NUSE_W    = 3;
  localparam int WORD_REGS = 4;
  localparam int TRIG_W    = 16;   // Q1.14 sine/cosine, signed
  localparam int TERM_W    = 39;   // sample * trig, at most 2^37 in magnitude

  // Shared multiplier: signed 33 x 33, so unsigned 32-bit operands fit too
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_WORD_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_WORD_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_WORD_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_WORD_3  = 3'd4;

  // Operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // Q30 coefficients of sin(pi/2 x) = c1 x - c3 x^3 + c5 x^5 - c7 x^7 + c9 x^9
  localparam logic [30:0] POLY_C1 = 31'd1686629713;
  localparam logic [30:0] POLY_C3 = 31'd693598668;
  localparam logic [30:0] POLY_C5 = 31'd85569305;
  localparam logic [30:0] POLY_C7 = 31'd5026990;
  localparam logic [30:0] POLY_C9 = 31'd172272;

  localparam logic [17:0] ONE_Q14 = 18'd16384;

  // Divider handshake back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Coefficient subtracted in Horner step 0..3
  function automatic logic [30:0] horner_coef(input logic [1:0] step);
    logic [30:0] c;
    unique case (step)
      2'd0: c = POLY_C7;
      2'd1: c = POLY_C5;
      2'd2: c = POLY_C3;
      2'd3: c = POLY_C1;
      default: c = POLY_C1;
    endcase
    return c;
  endfunction

endpackage

[rtl/rdfa_mul.sv]
module rdfa_mul import rdfa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Product registered; operands come straight from the sequencer mux
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/rdfa_div.sv]
module rdfa_div import rdfa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic signed [ACC_W-1:0] quotient_o,
  output div_stat_t               stat_o
);

  localparam int STEP_W = $clog2(ACC_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                neg_q, neg_d;
  logic [ACC_W-1:0]    quo_q, quo_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    den_q, den_d;
  logic [CNT_W:0]      shifted;
  logic [CNT_W+1:0]    diff;
  logic                ge;

  // Restoring division on magnitudes, one quotient bit a cycle
  always_comb begin
    shifted = {rem_q, quo_q[ACC_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = ~diff[CNT_W+1];
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(ACC_W - 1);
      neg_d  = dividend_i[ACC_W-1];
      quo_d  = dividend_i[ACC_W-1] ? (~$unsigned(dividend_i) + 1'b1) : $unsigned(dividend_i);
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[ACC_W-2:0], ge};
      rem_d  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Truncation toward zero: sign applied to the magnitude quotient
  assign quotient_o  = signed'(neg_q ? (~quo_q + 1'b1) : quo_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[rtl/running_dft_field_accumulator_core.sv]
// Running DFT accumulator. A sample transaction (operation 0) adds value*cos(theta) and
// value*sin(theta), theta = 2*pi*f*t, into the real and imaginary 64-bit saturating
// accumulators of its point for each of the first freqs_in_use frequency bins (capped at
// NUM_BINS and four), and a set snapshot_end counts one snapshot (saturating at 65535). A
// readout transaction (operation 1) returns one bin of one point divided by the snapshot
// count, truncated toward zero, or zeros with no_snapshots set when no snapshot was counted.
// All work goes through one shared registered 33x33 multiplier under a small sequencer:
// for each bin in use a sample runs a phase product, two sine polynomials, two sample
// products and two accumulator read-modify-writes. A readout is paced by the bit-serial
// divider that makes one quotient bit per cycle for each of the two averages; a readout
// with no snapshots counted skips the divider. After reset the block runs a clearing pass
// over all NUM_BINS*NUM_POINTS cells (4096 by default) that zeroes both accumulator
// memories; input stays stalled meanwhile, configuration writes are taken at any time.
// Results sit in an output register, so a finished readout waits there while the next
// transaction is accepted.
module running_dft_field_accumulator_core import rdfa_pkg::*; #(
  parameter int NUM_POINTS = 1024,
  parameter int NUM_BINS   = 4,
  parameter int PHASE_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [WORD_W-1:0]         cfg_data_i,

  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [POINT_W-1:0]        point_index_i,
  input  logic signed [VALUE_W-1:0] sample_value_i,
  input  logic [TIME_W-1:0]         time_metres_i,
  input  logic                      snapshot_end_i,
  input  logic [BIN_W-1:0]          bin_select_i,

  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [BIN_W-1:0]          out_bin_o,
  output logic [POINT_W-1:0]        out_point_o,
  output logic signed [ACC_W-1:0]   real_average_o,
  output logic signed [ACC_W-1:0]   imag_average_o,
  output logic                      no_snapshots_o
);

  localparam int CELLS     = NUM_BINS * NUM_POINTS;
  localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PB        = PHASE_BITS;
  localparam int QUARTER   = 1 << (PB - 2);
  localparam int PHASE_LSB = 42 - PB;          // phase = top PB fraction bits of Q42 turns
  localparam int X_SHIFT   = 32 - PB;          // quarter offset to Q30
  localparam int BINS_LIM  = (NUM_BINS < WORD_REGS) ? NUM_BINS : WORD_REGS;

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_CLEAR     = 20'h00002,
    S_PHASE     = 20'h00004,
    S_PHASE_CAP = 20'h00008,
    S_SQ        = 20'h00010,
    S_SQ_CAP    = 20'h00020,
    S_HORN      = 20'h00040,
    S_HORN_CAP  = 20'h00080,
    S_FIN       = 20'h00100,
    S_FIN_CAP   = 20'h00200,
    S_VMUL_C    = 20'h00400,
    S_VMUL_S    = 20'h00800,
    S_WR_RE     = 20'h01000,
    S_WR_IM     = 20'h02000,
    S_RD        = 20'h04000,
    S_DIVR      = 20'h08000,
    S_DIVR_W    = 20'h10000,
    S_DIVI      = 20'h20000,
    S_DIVI_W    = 20'h40000,
    S_OUT       = 20'h80000
  } state_e;

  // Saturating add of a product term to a 64-bit accumulator
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [TERM_W-1:0] term
  );
    logic [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum[ACC_W-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  state_e                     state_q, state_d;
  logic [NUSE_W-1:0]          freqs_q, freqs_d;
  logic [WORD_W-1:0]          fword_q [WORD_REGS];
  logic [WORD_W-1:0]          fword_d [WORD_REGS];
  logic [CNT_W-1:0]           snap_cnt_q, snap_cnt_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [BIN_W-1:0]           bin_q, bin_d;
  logic [1:0]                 k_q, k_d;
  logic                       sel_cos_q, sel_cos_d;
  logic                       out_valid_q, out_valid_d;

  // item and work registers
  logic [POINT_W-1:0]         point_q, point_d;
  logic signed [VALUE_W-1:0]  value_q, value_d;
  logic [TIME_W-1:0]          time_q, time_d;
  logic                       no_snap_q, no_snap_d;
  logic [PB-1:0]              phase_q, phase_d;
  logic [30:0]                x_q, x_d;
  logic [30:0]                x2_q, x2_d;
  logic [31:0]                p_q, p_d;
  logic signed [TRIG_W-1:0]   sin_q, sin_d, cos_q, cos_d;
  logic signed [TERM_W-1:0]   term_re_q, term_re_d, term_im_q, term_im_d;
  logic signed [ACC_W-1:0]    res_re_q, res_re_d, res_im_q, res_im_d;

  // output register
  logic [BIN_W-1:0]           out_bin_q;
  logic [POINT_W-1:0]         out_point_q;
  logic signed [ACC_W-1:0]    out_re_q, out_im_q;
  logic                       out_nosnap_q;
  logic                       out_load;

  // accumulator memories
  logic signed [ACC_W-1:0]    real_mem [CELLS];
  logic signed [ACC_W-1:0]    imag_mem [CELLS];
  logic signed [ACC_W-1:0]    rd_re_q, rd_im_q;
  logic                       real_we, imag_we, mem_re;
  logic [AW-1:0]              mem_addr;
  logic signed [ACC_W-1:0]    real_wdata, imag_wdata;
  logic [31:0]                cell_wide;
  logic [AW-1:0]              cell_addr;

  // shared multiplier
  logic                       mul_en;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;

  // divider
  logic                       div_start;
  logic signed [ACC_W-1:0]    div_dividend;
  logic signed [ACC_W-1:0]    div_quot;
  div_stat_t                  div_stat;

  // sine helpers
  logic [NUSE_W-1:0]          n_use;
  logic [PB-1:0]              cur_phase;
  logic [1:0]                 quad;
  logic [PB-2:0]              arg;
  logic [30:0]                x_cur;
  logic [33:0]                s_rnd;
  logic [17:0]                s_mag;
  logic [14:0]                s_cap;
  logic signed [TRIG_W-1:0]   trig;
  logic                       point_ok, bin_ok, out_free, in_acc;

  rdfa_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rdfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (snap_cnt_q),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  // Bins updated per sample: capped by the word registers and the memory
  assign n_use = (freqs_q > NUSE_W'(BINS_LIM)) ? NUSE_W'(BINS_LIM) : freqs_q;

  assign point_ok = 32'(point_index_i) < NUM_POINTS;
  assign bin_ok   = 32'(bin_select_i) < NUM_BINS;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Memory cell of (bin, point): bins are stacked NUM_POINTS apart
  assign cell_wide = 32'(bin_q) * 32'(NUM_POINTS) + 32'(point_q);
  assign cell_addr = cell_wide[AW-1:0];
  assign mem_addr  = (state_q == S_CLEAR) ? clr_q : cell_addr;

  // Sine argument: cosine is sine a quarter turn ahead
  assign cur_phase = phase_q + (sel_cos_q ? PB'(QUARTER) : PB'(0));
  assign quad      = cur_phase[PB-1:PB-2];
  assign arg       = quad[0] ? ((PB-1)'(QUARTER) - {1'b0, cur_phase[PB-3:0]})
                             : {1'b0, cur_phase[PB-3:0]};
  assign x_cur     = {arg, {X_SHIFT{1'b0}}};

  // Final polynomial product to Q1.14: round, cap at one, apply quadrant sign
  assign s_rnd = {1'b0, prod[62:30]} + 34'd32768;
  assign s_mag = s_rnd[33:16];
  assign s_cap = (s_mag > ONE_Q14) ? ONE_Q14[14:0] : s_mag[14:0];
  assign trig  = quad[1] ? (TRIG_W'(0) - {1'b0, s_cap}) : {1'b0, s_cap};

  assign real_wdata = (state_q == S_CLEAR) ? '0 : sat_add(rd_re_q, term_re_q);
  assign imag_wdata = (state_q == S_CLEAR) ? '0 : sat_add(rd_im_q, term_im_q);

  assign div_dividend = (state_q == S_DIVI) ? rd_im_q : rd_re_q;

  // Multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    unique case (state_q)
      S_PHASE: begin
        mul_a = MUL_W'(fword_q[bin_q]);
        mul_b = MUL_W'(time_q);
      end
      S_SQ: begin
        mul_a = MUL_W'(x_cur);
        mul_b = MUL_W'(x_cur);
      end
      S_HORN: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(x2_q);
      end
      S_FIN: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(x_q);
      end
      S_VMUL_C: begin
        mul_a = MUL_W'(value_q);
        mul_b = MUL_W'(cos_q);
      end
      S_VMUL_S: begin
        mul_a = MUL_W'(value_q);
        mul_b = MUL_W'(sin_q);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    freqs_d = freqs_q;
    fword_d = fword_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FREQS_IN_USE: freqs_d    = cfg_data_i[NUSE_W-1:0];
        CFG_FREQ_WORD_0:  fword_d[0] = cfg_data_i;
        CFG_FREQ_WORD_1:  fword_d[1] = cfg_data_i;
        CFG_FREQ_WORD_2:  fword_d[2] = cfg_data_i;
        CFG_FREQ_WORD_3:  fword_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    snap_cnt_d = snap_cnt_q;
    clr_d      = clr_q;
    bin_d      = bin_q;
    k_d        = k_q;
    sel_cos_d  = sel_cos_q;
    point_d    = point_q;
    value_d    = value_q;
    time_d     = time_q;
    no_snap_d  = no_snap_q;
    phase_d    = phase_q;
    x_d        = x_q;
    x2_d       = x2_q;
    p_d        = p_q;
    sin_d      = sin_q;
    cos_d      = cos_q;
    term_re_d  = term_re_q;
    term_im_d  = term_im_q;
    res_re_d   = res_re_q;
    res_im_d   = res_im_q;
    real_we    = 1'b0;
    imag_we    = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        real_we = 1'b1;
        imag_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          point_d = point_index_i;
          value_d = sample_value_i;
          time_d  = time_metres_i;
          if (operation_i == OP_SAMPLE) begin
            bin_d = '0;
            if (snapshot_end_i && (snap_cnt_q != '1)) begin
              snap_cnt_d = snap_cnt_q + 1'b1;
            end
            if (point_ok && (n_use != '0)) begin
              state_d = S_PHASE;
            end
          end else begin
            bin_d     = bin_select_i;
            no_snap_d = (snap_cnt_q == '0);
            if ((snap_cnt_q == '0) || !point_ok || !bin_ok) begin
              res_re_d = '0;
              res_im_d = '0;
              state_d  = S_OUT;
            end else begin
              state_d = S_RD;
            end
          end
        end
      end
      S_PHASE: begin
        state_d = S_PHASE_CAP;
      end
      S_PHASE_CAP: begin
        phase_d   = prod[PHASE_LSB +: PB];
        sel_cos_d = 1'b0;
        state_d   = S_SQ;
      end
      S_SQ: begin
        x_d     = x_cur;
        state_d = S_SQ_CAP;
      end
      S_SQ_CAP: begin
        x2_d    = prod[60:30];
        p_d     = {1'b0, POLY_C9};
        k_d     = '0;
        state_d = S_HORN;
      end
      S_HORN: begin
        state_d = S_HORN_CAP;
      end
      S_HORN_CAP: begin
        // each Horner term stays below its coefficient, so no wrap
        p_d = {1'b0, horner_coef(k_q)} - prod[61:30];
        k_d = k_q + 1'b1;
        state_d = (k_q == 2'd3) ? S_FIN : S_HORN;
      end
      S_FIN: begin
        state_d = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        if (sel_cos_q) begin
          cos_d   = trig;
          state_d = S_VMUL_C;
        end else begin
          sin_d     = trig;
          sel_cos_d = 1'b1;
          state_d   = S_SQ;
        end
      end
      S_VMUL_C: begin
        mem_re  = 1'b1;
        state_d = S_VMUL_S;
      end
      S_VMUL_S: begin
        term_re_d = prod[TERM_W-1:0];
        state_d   = S_WR_RE;
      end
      S_WR_RE: begin
        real_we   = 1'b1;
        term_im_d = prod[TERM_W-1:0];
        state_d   = S_WR_IM;
      end
      S_WR_IM: begin
        imag_we = 1'b1;
        if ((NUSE_W'(bin_q) + 1'b1) < n_use) begin
          bin_d   = bin_q + 1'b1;
          state_d = S_PHASE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_DIVR;
      end
      S_DIVR: begin
        div_start = 1'b1;
        state_d   = S_DIVR_W;
      end
      S_DIVR_W: begin
        if (div_stat.done) begin
          res_re_d = div_quot;
          state_d  = S_DIVI;
        end
      end
      S_DIVI: begin
        div_start = 1'b1;
        state_d   = S_DIVI_W;
      end
      S_DIVI_W: begin
        if (div_stat.done) begin
          res_im_d = div_quot;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: a taken result drops, a new one loads
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      freqs_q     <= NUSE_W'(1);
      fword_q     <= '{default: '0};
      snap_cnt_q  <= '0;
      clr_q       <= '0;
      bin_q       <= '0;
      k_q         <= '0;
      sel_cos_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      freqs_q     <= freqs_d;
      fword_q     <= fword_d;
      snap_cnt_q  <= snap_cnt_d;
      clr_q       <= clr_d;
      bin_q       <= bin_d;
      k_q         <= k_d;
      sel_cos_q   <= sel_cos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    point_q   <= point_d;
    value_q   <= value_d;
    time_q    <= time_d;
    no_snap_q <= no_snap_d;
    phase_q   <= phase_d;
    x_q       <= x_d;
    x2_q      <= x2_d;
    p_q       <= p_d;
    sin_q     <= sin_d;
    cos_q     <= cos_d;
    term_re_q <= term_re_d;
    term_im_q <= term_im_d;
    res_re_q  <= res_re_d;
    res_im_q  <= res_im_d;
    if (out_load) begin
      out_bin_q    <= bin_q;
      out_point_q  <= point_q;
      out_re_q     <= res_re_q;
      out_im_q     <= res_im_q;
      out_nosnap_q <= no_snap_q;
    end
  end

  // Accumulator memories: one port each, registered read
  always_ff @(posedge clk_i) begin
    if (real_we) begin
      real_mem[mem_addr] <= real_wdata;
    end
    if (imag_we) begin
      imag_mem[mem_addr] <= imag_wdata;
    end
    if (mem_re) begin
      rd_re_q <= real_mem[mem_addr];
      rd_im_q <= imag_mem[mem_addr];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_bin_o      = out_bin_q;
  assign out_point_o    = out_point_q;
  assign real_average_o = out_re_q;
  assign imag_average_o = out_im_q;
  assign no_snapshots_o = out_nosnap_q;

  // ---------------------------------------------------------------- checks
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the output step");

  a_nosnap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_nosnap_q) |-> (out_re_q == '0 && out_im_q == '0))
    else $error("nonzero average with no snapshots");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (snap_cnt_q != '0))
    else $error("division started with zero snapshot count");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PHASE) |-> (NUSE_W'(bin_q) < n_use))
    else $error("bin loop past bins in use");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_cnt_q != $past(snap_cnt_q)) |-> (snap_cnt_q == $past(snap_cnt_q) + 1)
       && $past(in_acc))
    else $error("snapshot count changed other than by one on a transaction");

endmodule

[test/running_dft_field_accumulator_core_tb.sv]
module running_dft_field_accumulator_core_tb;
  import rdfa_pkg::*;

  localparam int NUM_POINTS    = 1024;
  localparam int NUM_BINS      = 4;
  localparam int PHASE_BITS    = 12;
  localparam int SETTLE_CYCLES = 300;      // outlasts the longest transaction
  localparam int CYCLE_LIMIT   = 1000000;

  // Q30 coefficients of sin(pi/2 x), odd degree-9 fit
  localparam longint unsigned SIN_K1 = 64'd1686629713;
  localparam longint unsigned SIN_K3 = 64'd693598668;
  localparam longint unsigned SIN_K5 = 64'd85569305;
  localparam longint unsigned SIN_K7 = 64'd5026990;
  localparam longint unsigned SIN_K9 = 64'd172272;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
  localparam int     CNT_MAX = 65535;

  typedef struct {
    logic                      op;
    logic [POINT_W-1:0]        point;
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         tmetres;
    logic                      snap;
    logic [BIN_W-1:0]          bin;
  } field_txn_t;

  typedef struct {
    logic [BIN_W-1:0]        bin;
    logic [POINT_W-1:0]      point;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic                    empty;
  } dft_average_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = CFG_FREQS_IN_USE;
  logic [WORD_W-1:0]         cfg_data_i = '0;

  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      operation_i = OP_SAMPLE;
  logic [POINT_W-1:0]        point_index_i = '0;
  logic signed [VALUE_W-1:0] sample_value_i = '0;
  logic [TIME_W-1:0]         time_metres_i = '0;
  logic                      snapshot_end_i = 1'b0;
  logic [BIN_W-1:0]          bin_select_i = '0;

  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [BIN_W-1:0]          out_bin_o;
  logic [POINT_W-1:0]        out_point_o;
  logic signed [ACC_W-1:0]   real_average_o;
  logic signed [ACC_W-1:0]   imag_average_o;
  logic                      no_snapshots_o;

  running_dft_field_accumulator_core #(
    .NUM_POINTS (NUM_POINTS),
    .NUM_BINS   (NUM_BINS),
    .PHASE_BITS (PHASE_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .point_index_i  (point_index_i),
    .sample_value_i (sample_value_i),
    .time_metres_i  (time_metres_i),
    .snapshot_end_i (snapshot_end_i),
    .bin_select_i   (bin_select_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_bin_o      (out_bin_o),
    .out_point_o    (out_point_o),
    .real_average_o (real_average_o),
    .imag_average_o (imag_average_o),
    .no_snapshots_o (no_snapshots_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the accumulators, counter and registers
  // ---------------------------------------------------------------------------
  longint              real_acc [NUM_BINS*NUM_POINTS];
  longint              imag_acc [NUM_BINS*NUM_POINTS];
  int                  snap_count = 0;
  logic [NUSE_W-1:0]   bins_cfg = 3'd1;
  logic [WORD_W-1:0]   word_cfg [WORD_REGS];

  field_txn_t   txn_queue [$];      // transactions waiting for the driver
  dft_average_t average_fifo [$];   // readout results still owed by the DUT

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int err_count       = 0;
  int n_samples       = 0;
  int n_readouts      = 0;
  int n_checked       = 0;
  int n_settings      = 0;
  int cycle_count     = 0;
  logic in_taken      = 1'b0;

  // Points that get hit often so readouts see sums of many samples
  int hot_points [8] = '{0, 1023, 5, 77, 300, 512, 640, 1000};

  // sin(pi/2 * r/Q) for r in 0..Q, Q1.14, from the Q30 Horner evaluation
  function automatic longint quarter_wave(int unsigned r);
    longint unsigned x, x2, acc, s;
    x   = r;
    x   = x << (30 - (PHASE_BITS - 2));
    x2  = (x * x) >> 30;
    acc = SIN_K9;
    acc = SIN_K7 - ((acc * x2) >> 30);
    acc = SIN_K5 - ((acc * x2) >> 30);
    acc = SIN_K3 - ((acc * x2) >> 30);
    acc = SIN_K1 - ((acc * x2) >> 30);
    s   = (acc * x) >> 30;
    s   = (s + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return longint'(s);
  endfunction

  // full-circle sine by quadrant folding
  function automatic longint trig_q14(int unsigned phase);
    int unsigned quarter, p, quad, r;
    longint v;
    quarter = 1 << (PHASE_BITS - 2);
    p       = phase & ((1 << PHASE_BITS) - 1);
    quad    = p >> (PHASE_BITS - 2);
    r       = p & (quarter - 1);
    v       = ((quad & 1) != 0) ? quarter_wave(quarter - r) : quarter_wave(r);
    return ((quad & 2) != 0) ? -v : v;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // Applies the transaction on the input ports (accepted this edge) to the
  // predicted state; a readout queues the averages the DUT must return.
  task automatic predict_dft_txn();
    int unsigned  n, b, slot, ph;
    logic [63:0]  prod;
    longint       v, s, c, re, im;
    dft_average_t res;
    if (operation_i == OP_SAMPLE) begin
      n = (bins_cfg > WORD_REGS) ? WORD_REGS : bins_cfg;
      if (n > NUM_BINS) begin
        n = NUM_BINS;
      end
      v = longint'(sample_value_i);
      for (b = 0; b < n; b++) begin
        prod = {32'd0, word_cfg[b]} * {32'd0, time_metres_i};
        ph   = prod[42-PHASE_BITS +: PHASE_BITS];
        s    = trig_q14(ph);
        c    = trig_q14(ph + (1 << (PHASE_BITS - 2)));
        slot = b * NUM_POINTS + point_index_i;
        real_acc[slot] = sat_sum(real_acc[slot], v * c);
        imag_acc[slot] = sat_sum(imag_acc[slot], v * s);
      end
      if (snapshot_end_i && snap_count < CNT_MAX) begin
        snap_count++;
      end
      n_samples++;
    end else begin
      re = 0;
      im = 0;
      if (snap_count != 0 && point_index_i < NUM_POINTS && bin_select_i < NUM_BINS) begin
        slot = bin_select_i * NUM_POINTS + point_index_i;
        re   = real_acc[slot] / longint'(snap_count);   // truncates toward zero
        im   = imag_acc[slot] / longint'(snap_count);
      end
      res.bin   = bin_select_i;
      res.point = point_index_i;
      res.re    = re;
      res.im    = im;
      res.empty = (snap_count == 0);
      average_fifo.push_back(res);
      n_readouts++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new transaction is loaded only
  // once the previous one was accepted; the payload holds while stalled.
  // ---------------------------------------------------------------------------
  field_txn_t next_txn;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (!in_valid_i || in_taken) begin
      if (txn_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_txn        = txn_queue.pop_front();
        in_valid_i     <= 1'b1;
        operation_i    <= next_txn.op;
        point_index_i  <= next_txn.point;
        sample_value_i <= next_txn.value;
        time_metres_i  <= next_txn.tmetres;
        snapshot_end_i <= next_txn.snap;
        bin_select_i   <= next_txn.bin;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge; predict on input
  // acceptance, compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  dft_average_t want;

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_dft_txn();
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (average_fifo.size() == 0) begin
        err_count++;
        $display("%0t: result expected none actual bin %0d point %0d re %0d im %0d",
                 $time, out_bin_o, out_point_o, real_average_o, imag_average_o);
      end else begin
        want = average_fifo.pop_front();
        n_checked++;
        if (out_bin_o !== want.bin) begin
          err_count++;
          $display("%0t: out_bin expected %0d actual %0d", $time, want.bin, out_bin_o);
        end
        if (out_point_o !== want.point) begin
          err_count++;
          $display("%0t: out_point expected %0d actual %0d", $time, want.point,
                   out_point_o);
        end
        if (real_average_o !== want.re) begin
          err_count++;
          $display("%0t: real_average expected %0d actual %0d", $time, want.re,
                   real_average_o);
        end
        if (imag_average_o !== want.im) begin
          err_count++;
          $display("%0t: imag_average expected %0d actual %0d", $time, want.im,
                   imag_average_o);
        end
        if (no_snapshots_o !== want.empty) begin
          err_count++;
          $display("%0t: no_snapshots expected %0d actual %0d", $time, want.empty,
                   no_snapshots_o);
        end
      end
    end
  end

  // Watchdog; covers the clearing pass and the slowest traffic phases
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               average_fifo.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic field_txn_t mk_txn(logic op, int point, int value,
                                        logic [31:0] tm, logic snap, int bin);
    field_txn_t t;
    t.op      = op;
    t.point   = point[POINT_W-1:0];
    t.value   = value[VALUE_W-1:0];
    t.tmetres = tm;
    t.snap    = snap;
    t.bin     = bin[BIN_W-1:0];
    return t;
  endfunction

  function automatic field_txn_t rand_txn(int read_pct, int snap_pct);
    field_txn_t  t;
    logic [31:0] rnd;
    rnd       = $urandom();
    t.op      = ($urandom_range(99) < read_pct) ? OP_READOUT : OP_SAMPLE;
    t.point   = POINT_W'(($urandom_range(9) < 7) ? hot_points[$urandom_range(7)]
                                                 : $urandom_range(NUM_POINTS - 1));
    t.value   = rnd[VALUE_W-1:0];
    case ($urandom_range(15))
      0: t.value = {1'b1, {(VALUE_W-1){1'b0}}};   // most negative sample
      1: t.value = {1'b0, {(VALUE_W-1){1'b1}}};   // most positive sample
      default: ;
    endcase
    t.tmetres = $urandom();
    t.snap    = ($urandom_range(99) < snap_pct);
    t.bin     = BIN_W'($urandom_range(NUM_BINS - 1));
    return t;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_random(int count);
    for (int k = 0; k < count; k++) begin
      txn_queue.push_back(rand_txn(30, 15));
    end
  endtask

  // writes all five registers back to back, one per falling edge
  task automatic program_bins(logic [NUSE_W-1:0] n, logic [31:0] w0, logic [31:0] w1,
                              logic [31:0] w2, logic [31:0] w3);
    logic [CFG_IDX_W-1:0] idx  [5];
    logic [WORD_W-1:0]    data [5];
    idx  = '{CFG_FREQS_IN_USE, CFG_FREQ_WORD_0, CFG_FREQ_WORD_1, CFG_FREQ_WORD_2,
             CFG_FREQ_WORD_3};
    data = '{{29'd0, n}, w0, w1, w2, w3};
    for (int k = 0; k < 5; k++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= data[k];
    end
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    bins_cfg    = n;
    word_cfg[0] = w0;
    word_cfg[1] = w1;
    word_cfg[2] = w2;
    word_cfg[3] = w3;
    n_settings++;
  endtask

  // Sender holds off until every owed result is back, then lets the last
  // sample (which returns nothing) finish before anything else happens.
  task automatic settle();
    do @(posedge clk_i);
    while (txn_queue.size() != 0 || in_valid_i || average_fifo.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
  task automatic set_traffic(int mode);
    sender_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 33 : 0;
    recv_stall_pct  = (mode == 2) ? 56 : (mode == 3) ? 33 : 0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [NUSE_W-1:0] phase_bins [8] = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd2, 3'd3, 3'd5, 3'd4};
  int                qpt [6] = '{1023, 1024, 2047, 2048, 3072, 4095};

  initial begin
    for (int i = 0; i < NUM_BINS*NUM_POINTS; i++) begin
      real_acc[i] = 0;
      imag_acc[i] = 0;
    end
    for (int i = 0; i < WORD_REGS; i++) begin
      word_cfg[i] = '0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Word 0 = 2^20 makes the phase equal time >> 10, so the
    // time values below land on the quadrant edges of the sine table.
    set_traffic(0);
    program_bins(3'd4, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0000, $urandom());
    // readouts before any snapshot: zeros with the flag; snapshot_end ignored
    txn_queue.push_back(mk_txn(OP_READOUT, 0, 0, 32'h0, 1'b0, 0));
    txn_queue.push_back(mk_txn(OP_READOUT, 1023, -1, 32'hFFFF_FFFF, 1'b1, 3));
    // sample extremes
    txn_queue.push_back(mk_txn(OP_SAMPLE, 0, 8388607, 32'h0, 1'b0, 0));
    txn_queue.push_back(mk_txn(OP_SAMPLE, 0, -8388608, 32'hFFFF_FFFF, 1'b0, 3));
    for (int k = 0; k < 6; k++) begin
      txn_queue.push_back(mk_txn(OP_SAMPLE, 1023, (k % 2) ? -8388608 : 8388607,
                                 qpt[k] << 10, k == 5, k % 4));
    end
    txn_queue.push_back(mk_txn(OP_SAMPLE, 1023, -1, 32'h0, 1'b1, 0));
    for (int b = 0; b < NUM_BINS; b++) begin
      txn_queue.push_back(mk_txn(OP_READOUT, 0, 0, 32'h0, 1'b0, b));
    end
    txn_queue.push_back(mk_txn(OP_READOUT, 1023, 0, 32'h0, 1'b0, 0));
    txn_queue.push_back(mk_txn(OP_READOUT, 1023, 0, 32'h0, 1'b0, 1));
    txn_queue.push_back(mk_txn(OP_SAMPLE, 512, 0, $urandom(), 1'b1, 0));
    txn_queue.push_back(mk_txn(OP_READOUT, 512, 0, 32'h0, 1'b0, 2));
    settle();

    // Random phases, each with its own register setting and traffic pattern.
    // Bin counts cover zero, the top of the range and the clamped 5..7.
    for (int ph = 0; ph < 8; ph++) begin
      set_traffic(ph % 4);
      program_bins(phase_bins[ph], pick_word(), pick_word(), pick_word(), pick_word());
      if (ph == 5) begin
        // sender pauses mid-phase until the result channel is empty
        push_random(50);
        settle();
        push_random(50);
      end else begin
        push_random(100);
      end
      settle();
    end

    // No bins in use: samples only bump the snapshot count, so the readouts
    // that follow divide the same sums by a larger count.
    set_traffic(2);
    program_bins(3'd0, pick_word(), pick_word(), pick_word(), pick_word());
    for (int k = 0; k < 16; k++) begin
      txn_queue.push_back(mk_txn(OP_SAMPLE, $urandom_range(NUM_POINTS - 1), $urandom(),
                                 $urandom(), 1'b1, 0));
    end
    for (int k = 0; k < 8; k++) begin
      txn_queue.push_back(mk_txn(OP_READOUT, hot_points[k], 0, 32'h0, 1'b1, k % 4));
    end
    settle();

    $display("run covered %0d samples and %0d readouts across %0d register settings",
             n_samples, n_readouts, n_settings);
    $display("%0d averages compared, snapshot count ended at %0d, %0d mismatches",
             n_checked, snap_count, err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
